### hdl/bpsfl_pkg.sv
// Shared types and constants for the byte pattern search block.
// Used by the window cells, the match tracker and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bpsfl_pkg;

  localparam int BYTE_W    = 8;
  localparam int PATTERN_W = 64;
  localparam int LEN_W     = 4;
  localparam int OFFSET_W  = 16;

  // Configuration register indexes
  localparam logic REG_PATTERN_BYTES  = 1'b0;
  localparam logic REG_PATTERN_LENGTH = 1'b1;

  // Control for the window cells
  typedef struct packed {
    logic shift;  // move each byte one cell further
    logic clear;  // drop the buffer at its end
  } cell_ctl_t;

  // One accepted word as seen by the tracker
  typedef struct packed {
    logic accept;
    logic last;
    logic hit;    // window matches, before the length bound is applied
  } step_t;

endpackage

`default_nettype wire

### hdl/bpsfl_cell.sv
// One cell of the search window: holds one byte and its valid bit.
// Compares the byte it is about to take with its pattern byte. Uses bpsfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpsfl_cell #(
  parameter int IDX = 0
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire bpsfl_pkg::cell_ctl_t          ctl,
  input  wire [bpsfl_pkg::BYTE_W-1:0]        in_byte,
  input  wire                                in_valid,
  input  wire [bpsfl_pkg::PATTERN_W-1:0]     pattern_bytes,
  input  wire [bpsfl_pkg::LEN_W-1:0]         len,
  output logic [bpsfl_pkg::BYTE_W-1:0]       out_byte,
  output logic                               out_valid,
  output logic                               hit
);
  import bpsfl_pkg::*;

  localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

  logic [LEN_W-1:0]     sel;
  logic [PATTERN_W-1:0] pat_shift;
  logic                 used;

  // Pattern byte that lines up with this cell: len - 1 - IDX
  assign sel       = len - MY_IDX - LEN_W'(1);
  assign pat_shift = pattern_bytes >> {sel[2:0], 3'b000};
  assign used      = (len > MY_IDX);

  // Cells past the pattern length always agree
  assign hit = !used || (in_valid && (in_byte == pat_shift[BYTE_W-1:0]));

  // Byte and valid bit, handed on each shift
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      out_valid <= 1'b0;
      out_byte  <= '0;
    end else if (ctl.shift) begin
      out_valid <= in_valid;
      out_byte  <= in_byte;
    end
  end

endmodule

`default_nettype wire

### hdl/bpsfl_tracker.sv
// Byte counter, first and last match offsets, and the result register.
// Uses bpsfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpsfl_tracker #(
  parameter int MAX_BUFFER_BYTES = 65536
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire bpsfl_pkg::step_t              step,
  input  wire [bpsfl_pkg::LEN_W-1:0]         len,
  input  wire                                out_stall,
  output logic                               room,
  output logic                               out_valid,
  output logic                               found,
  output logic [bpsfl_pkg::OFFSET_W-1:0]     first_offset,
  output logic [bpsfl_pkg::OFFSET_W-1:0]     last_offset,
  output logic                               overflow
);
  import bpsfl_pkg::*;

  localparam int CW = $clog2(MAX_BUFFER_BYTES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BUFFER_BYTES);

  logic [CW-1:0]          bytes_seen;
  logic                   match_seen;
  logic [OFFSET_W-1:0]    earliest_start;
  logic [OFFSET_W-1:0]    latest_start;
  logic                   length_exceeded;

  logic [CW-1:0]          bytes_seen_next;
  logic                   match_seen_next;
  logic [OFFSET_W-1:0]    earliest_start_next;
  logic [OFFSET_W-1:0]    latest_start_next;
  logic                   length_exceeded_next;
  logic [CW-1:0]          start;
  logic [CW+OFFSET_W-1:0] start_wide;
  logic                   take;

  assign room       = (bytes_seen < MAX_CNT);
  assign start      = bytes_seen + CW'(1) - {{(CW-LEN_W){1'b0}}, len};
  assign start_wide = {{OFFSET_W{1'b0}}, start};
  assign take       = step.accept && room && step.hit;

  // Per-buffer state update for one accepted word
  always_comb begin
    bytes_seen_next      = bytes_seen;
    match_seen_next      = match_seen;
    earliest_start_next  = earliest_start;
    latest_start_next    = latest_start;
    length_exceeded_next = length_exceeded;
    if (step.accept) begin
      if (room) begin
        bytes_seen_next = bytes_seen + CW'(1);
      end else begin
        length_exceeded_next = 1'b1;
      end
    end
    if (take) begin
      if (!match_seen) begin
        earliest_start_next = start_wide[OFFSET_W-1:0];
      end
      latest_start_next = start_wide[OFFSET_W-1:0];
      match_seen_next   = 1'b1;
    end
  end

  // Tracker registers, cleared after the last word of a buffer
  always_ff @(posedge clk) begin
    if (rst || (step.accept && step.last)) begin
      bytes_seen      <= '0;
      match_seen      <= 1'b0;
      earliest_start  <= '0;
      latest_start    <= '0;
      length_exceeded <= 1'b0;
    end else begin
      bytes_seen      <= bytes_seen_next;
      match_seen      <= match_seen_next;
      earliest_start  <= earliest_start_next;
      latest_start    <= latest_start_next;
      length_exceeded <= length_exceeded_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step.accept && step.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.accept && step.last) begin
      found        <= match_seen_next;
      first_offset <= match_seen_next ? earliest_start_next : '0;
      last_offset  <= match_seen_next ? latest_start_next : '0;
      overflow     <= length_exceeded_next;
    end
  end

endmodule

`default_nettype wire

### hdl/byte_pattern_search_first_last.sv
// Streaming byte pattern search, reporting first and last match offsets.
// Result word is valid in the cycle after the word carrying last_byte is accepted.
// Throughput: one byte per cycle; the row of window cells compares in parallel.
// Input is stalled only while a result is held by a stalled output.
// Reset (rst, synchronous): pattern registers, window and counters go to zero.
`timescale 1ns / 1ps
`default_nettype none

module byte_pattern_search_first_last #(
  parameter int PATTERN_MAX_BYTES = 8,
  parameter int MAX_BUFFER_BYTES  = 65536
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_write_en,
  input  wire                                cfg_index,
  input  wire [bpsfl_pkg::PATTERN_W-1:0]     cfg_data,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire [bpsfl_pkg::BYTE_W-1:0]        data_byte,
  input  wire                                last_byte,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               found,
  output logic [bpsfl_pkg::OFFSET_W-1:0]     first_offset,
  output logic [bpsfl_pkg::OFFSET_W-1:0]     last_offset,
  output logic                               overflow
);
  import bpsfl_pkg::*;

  localparam int PM = PATTERN_MAX_BYTES;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(PATTERN_MAX_BYTES);

  logic [PATTERN_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]     pattern_length;
  logic [LEN_W-1:0]     len;
  logic                 accept;
  logic                 room;
  cell_ctl_t            ctl;
  step_t                step;

  logic [BYTE_W-1:0]    chain_byte  [PM+1];
  logic                 chain_valid [PM+1];
  logic [PM-1:0]        cell_hit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Length saturates at the window size
  assign len = (pattern_length > LEN_CAP) ? LEN_CAP : pattern_length;

  // Handshake
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign ctl.shift = accept && room;
  assign ctl.clear = accept && last_byte;

  // Row of window cells, newest byte enters cell 0
  assign chain_byte[0]  = data_byte;
  assign chain_valid[0] = 1'b1;

  for (genvar i = 0; i < PM; i++) begin : g_cell
    bpsfl_cell #(
      .IDX (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .in_byte       (chain_byte[i]),
      .in_valid      (chain_valid[i]),
      .pattern_bytes (pattern_bytes),
      .len           (len),
      .out_byte      (chain_byte[i+1]),
      .out_valid     (chain_valid[i+1]),
      .hit           (cell_hit[i])
    );
  end

  assign step.accept = accept;
  assign step.last   = last_byte;
  assign step.hit    = (len != '0) && (&cell_hit);

  bpsfl_tracker #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_tracker (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .len          (len),
    .out_stall    (out_stall),
    .room         (room),
    .out_valid    (out_valid),
    .found        (found),
    .first_offset (first_offset),
    .last_offset  (last_offset),
    .overflow     (overflow)
  );

endmodule

`default_nettype wire

### hdl/bpsfl_checker.sv
// Port-level checks for byte_pattern_search_first_last, bound to the top level.
// Uses bpsfl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module bpsfl_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                in_valid,
  input wire                                in_stall,
  input wire                                last_byte,
  input wire                                out_valid,
  input wire                                out_stall,
  input wire                                found,
  input wire [bpsfl_pkg::OFFSET_W-1:0]      first_offset,
  input wire [bpsfl_pkg::OFFSET_W-1:0]      last_offset
);
  import bpsfl_pkg::*;

  // Held result word keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found)
      && $stable(first_offset) && $stable(last_offset))
    else $error("held result word changed");

  // Input stalls exactly when a result is blocked
  assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  // Last byte accepted yields a result word next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_byte |=> out_valid)
    else $error("no result after last byte");

  // No match reports zero offsets
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> first_offset == '0 && last_offset == '0)
    else $error("offsets nonzero without a match");

endmodule

bind byte_pattern_search_first_last bpsfl_checker u_bpsfl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .last_byte    (last_byte),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .found        (found),
  .first_offset (first_offset),
  .last_offset  (last_offset)
);

`default_nettype wire
